FILE: rtl/assert_macros.svh
// assertion macros used by the top-level color parser
// no dependencies; assertions are compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion lbl failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    `ASSERT_CLK(lbl, clk, rstn, !(cond))
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: rtl/asgr_pkg.sv
// types, character codes and the sgr parameter decode for the color parser
// no dependencies
package asgr_pkg;

    localparam logic [7:0] CHR_ESC   = 8'd27;
    localparam logic [7:0] CHR_LBRKT = 8'h5B;
    localparam logic [7:0] CHR_SEMI  = 8'h3B;
    localparam logic [7:0] CHR_M     = 8'h6D;
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_D0    = 8'h30;
    localparam logic [7:0] CHR_D9    = 8'h39;

    localparam logic [3:0] FG_DEFAULT = 4'd15;
    localparam logic [3:0] BG_DEFAULT = 4'd0;
    localparam logic [3:0] BRIGHT_MASK = 4'h8;
    localparam logic [2:0] LOW_DEFAULT = 3'h7;

    localparam logic [7:0] SGR_RESET     = 8'd0;
    localparam logic [7:0] SGR_BRIGHT    = 8'd1;
    localparam logic [7:0] SGR_NO_BRIGHT = 8'd11;
    localparam logic [7:0] SGR_FG_BASE   = 8'd30;
    localparam logic [7:0] SGR_FG_LAST   = 8'd37;
    localparam logic [7:0] SGR_FG_DEF    = 8'd39;
    localparam logic [7:0] SGR_BG_BASE   = 8'd40;
    localparam logic [7:0] SGR_BG_LAST   = 8'd47;
    localparam logic [7:0] SGR_BG_DEF    = 8'd49;

    localparam logic [7:0] PARAM_MAX = 8'd255;

    typedef enum logic [1:0] {
        PH_TEXT  = 2'd0,
        PH_ESC   = 2'd1,
        PH_PARAM = 2'd2
    } phase_t;

    typedef struct packed {
        logic [3:0] fg;
        logic [3:0] bg;
    } color_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] value;
        logic       closed;
        color_t     color;
    } sgr_state_t;

    // apply one sgr parameter to the current colors
    function automatic color_t apply_sgr(logic [7:0] v, color_t c);
        color_t     r;
        logic [7:0] d_fg;
        logic [7:0] d_bg;
        r    = c;
        d_fg = v - SGR_FG_BASE;
        d_bg = v - SGR_BG_BASE;
        if (v == SGR_RESET)
        begin
            r.fg = FG_DEFAULT;
            r.bg = BG_DEFAULT;
        end
        else if (v == SGR_BRIGHT)
        begin
            r.fg = c.fg | BRIGHT_MASK;
        end
        else if (v == SGR_NO_BRIGHT)
        begin
            r.fg = c.fg & ~BRIGHT_MASK;
        end
        else if (v >= SGR_FG_BASE && v <= SGR_FG_LAST)
        begin
            r.fg = {c.fg[3], d_fg[2:0]};
        end
        else if (v == SGR_FG_DEF)
        begin
            r.fg = {c.fg[3], LOW_DEFAULT};
        end
        else if (v >= SGR_BG_BASE && v <= SGR_BG_LAST)
        begin
            r.bg = {c.bg[3], d_bg[2:0]};
        end
        else if (v == SGR_BG_DEF)
        begin
            r.bg = {c.bg[3], LOW_DEFAULT};
        end
        return r;
    endfunction

endpackage

FILE: rtl/asgr_in_stage.sv
// input register of the color parser: holds one word until the step logic takes it
// depends on nothing but the port list
module asgr_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       take,
    output logic       hold_valid,
    output logic [7:0] hold_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       accept;

    // stall while a held word is not being taken
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_byte;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule

FILE: rtl/asgr_step.sv
// per-byte parser step: next phase, parameter build and color update
// depends on asgr_pkg
module asgr_step
(
    input  logic [7:0]          in_byte,
    input  asgr_pkg::sgr_state_t cur,
    output asgr_pkg::sgr_state_t nxt,
    output logic                text
);

    logic        is_nul;
    logic        is_digit;
    logic        is_semi;
    logic        is_m;
    logic        is_esc;
    logic        is_lbrkt;
    logic [11:0] prod;
    logic [7:0]  value_acc;
    asgr_pkg::color_t applied;
    asgr_pkg::phase_t phase_next;

    // byte classes
    assign is_nul   = (in_byte == asgr_pkg::CHR_NUL);
    assign is_digit = (in_byte >= asgr_pkg::CHR_D0) && (in_byte <= asgr_pkg::CHR_D9);
    assign is_semi  = (in_byte == asgr_pkg::CHR_SEMI);
    assign is_m     = (in_byte == asgr_pkg::CHR_M);
    assign is_esc   = (in_byte == asgr_pkg::CHR_ESC);
    assign is_lbrkt = (in_byte == asgr_pkg::CHR_LBRKT);

    // value * 10 + digit, saturating at 255; digit is the low nibble of '0'..'9'
    assign prod = ({4'd0, cur.value} << 3) + ({4'd0, cur.value} << 1)
                + {8'd0, in_byte[3:0]};
    assign value_acc = (prod[11:8] != 4'd0) ? asgr_pkg::PARAM_MAX : prod[7:0];

    assign applied = asgr_pkg::apply_sgr(cur.value, cur.color);

    // next phase
    always_comb
    begin
        phase_next = asgr_pkg::PH_TEXT;
        unique case (cur.phase)
            asgr_pkg::PH_ESC:
            begin
                if (is_lbrkt)
                begin
                    phase_next = asgr_pkg::PH_PARAM;
                end
                else if (is_esc)
                begin
                    phase_next = asgr_pkg::PH_ESC;
                end
            end
            asgr_pkg::PH_PARAM:
            begin
                if (!is_nul && !is_m)
                begin
                    phase_next = asgr_pkg::PH_PARAM;
                end
            end
            default:
            begin
                if (is_esc)
                begin
                    phase_next = asgr_pkg::PH_ESC;
                end
            end
        endcase
    end

    // parameter, colors and text flag
    always_comb
    begin
        nxt.phase  = phase_next;
        nxt.value  = cur.value;
        nxt.closed = cur.closed;
        nxt.color  = cur.color;
        text       = 1'b0;
        unique case (cur.phase)
            asgr_pkg::PH_ESC:
            begin
                if (is_lbrkt)
                begin
                    nxt.value  = 8'd0;
                    nxt.closed = 1'b0;
                end
                else
                begin
                    text = !is_esc;
                end
            end
            asgr_pkg::PH_PARAM:
            begin
                priority if (is_nul)
                begin
                    nxt.value  = 8'd0;
                    nxt.closed = 1'b0;
                end
                else if (is_digit)
                begin
                    if (!cur.closed)
                    begin
                        nxt.value = value_acc;
                    end
                end
                else if (is_semi || is_m)
                begin
                    nxt.color  = applied;
                    nxt.value  = 8'd0;
                    nxt.closed = 1'b0;
                end
                else
                begin
                    nxt.closed = 1'b1;
                end
            end
            default:
            begin
                text = !is_esc;
            end
        endcase
    end

endmodule

FILE: rtl/ansi_sgr_color_parser.sv
// ansi sgr color parser: bytes pass the input register, then the result register;
// throughput one byte per cycle while out_stall is low; the parse state and colors
// update in the same cycle the held word moves into the result register.
// reset: asynchronous active low; colors return to fg 15, bg 0, plain text,
// no word held. depends on asgr_pkg, asgr_in_stage, asgr_step, assert_macros.svh
`include "assert_macros.svh"

module ansi_sgr_color_parser
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       is_text,
    output logic [3:0] fg_color,
    output logic [3:0] bg_color
);

    logic                 hold_valid;
    logic [7:0]           hold_byte;
    logic                 take;
    logic                 text_next;
    asgr_pkg::sgr_state_t state_reg;
    asgr_pkg::sgr_state_t state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_byte_reg;
    logic                 is_text_reg;

    // held word moves on when the result register is empty or being drained
    assign take = hold_valid && (!out_valid_reg || !out_stall);

    asgr_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .take       (take),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    asgr_step u_step
    (
        .in_byte (hold_byte),
        .cur     (state_reg),
        .nxt     (state_next),
        .text    (text_next)
    );

    assign out_valid_next = take || (out_valid_reg && out_stall);

    // parse state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase    <= asgr_pkg::PH_TEXT;
            state_reg.value    <= 8'd0;
            state_reg.closed   <= 1'b0;
            state_reg.color.fg <= asgr_pkg::FG_DEFAULT;
            state_reg.color.bg <= asgr_pkg::BG_DEFAULT;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_byte_reg <= hold_byte;
            is_text_reg  <= text_next;
        end
    end

    // colors only change when a word is loaded, so they track the result word
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_text   = is_text_reg;
    assign fg_color  = state_reg.color.fg;
    assign bg_color  = state_reg.color.bg;

    // bytes inside a parameter list are never display text
    `ASSERT_CLK(a_param_not_text, clk, rst_n,
        (take && state_reg.phase == asgr_pkg::PH_PARAM) |=> !is_text_reg)
    // parameter accumulator is clear outside a parameter list
    `ASSERT_CLK(a_param_clear, clk, rst_n,
        (state_reg.phase != asgr_pkg::PH_PARAM) |->
            (state_reg.value == 8'd0 && !state_reg.closed))
    // colors hold while no word moves
    `ASSERT_CLK(a_color_hold, clk, rst_n, !take |=> $stable(state_reg.color))
    // input stalls only while a word is held
    `ASSERT_NEVER(a_stall_empty, clk, rst_n, in_stall && !hold_valid)

endmodule
